@@ src/pidts_pkg.sv @@
`default_nettype none

package pidts_pkg;

   // Default number of fraction bits on speeds, gains and servo position
   localparam int FRAC_BITS_DEFAULT = 8;

   // Field widths
   localparam int SPEED_W    = 16;
   localparam int GAIN_W     = 16;
   localparam int ERR_W      = SPEED_W + 1;
   localparam int DERR_W     = ERR_W + 1;
   localparam int INTEG_W    = 24;
   localparam int ILIM_W     = 23;
   localparam int SLEW_W     = 16;
   localparam int PULSE_W    = 12;
   localparam int DELTA_W    = 24;
   localparam int STEP_W     = SLEW_W + 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 23;

   // Product and sum widths of the PID increment
   localparam int PROD_P_W = GAIN_W + ERR_W;
   localparam int PROD_I_W = GAIN_W + INTEG_W;
   localparam int PROD_D_W = GAIN_W + DERR_W;
   localparam int SUM_W    = PROD_I_W + 2;

   // Servo position after reset, whole microseconds
   localparam logic [PULSE_W-1:0] PULSE_RESET = 12'd1565;

   // Register reset values
   localparam logic signed [GAIN_W-1:0] P_GAIN_RESET  = 16'sd256;
   localparam logic signed [GAIN_W-1:0] I_GAIN_RESET  = 16'sd0;
   localparam logic signed [GAIN_W-1:0] D_GAIN_RESET  = 16'sd0;
   localparam logic [ILIM_W-1:0]        ILIM_RESET    = 23'd2560;
   localparam logic [SLEW_W-1:0]        SLEW_RESET    = 16'd2560;
   localparam logic [PULSE_W-1:0]       PMAX_RESET    = 12'd2000;
   localparam logic [PULSE_W-1:0]       PMIN_RESET    = 12'd1000;

   // Register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_P_GAIN     = 3'd0,
      CSR_I_GAIN     = 3'd1,
      CSR_D_GAIN     = 3'd2,
      CSR_INTEG_LIM  = 3'd3,
      CSR_SLEW_LIM   = 3'd4,
      CSR_PULSE_MAX  = 3'd5,
      CSR_PULSE_MIN  = 3'd6
   } csr_index_type;

   // Configuration bundle handed to the datapath
   typedef struct packed {
      logic signed [GAIN_W-1:0] p_gain;
      logic signed [GAIN_W-1:0] i_gain;
      logic signed [GAIN_W-1:0] d_gain;
      logic [ILIM_W-1:0]        integ_limit;
      logic [SLEW_W-1:0]        slew_limit;
      logic [PULSE_W-1:0]       pulse_max;
      logic [PULSE_W-1:0]       pulse_min;
   } cfg_type;

endpackage

`default_nettype wire

@@ src/pid_throttle_slew_limited_core.sv @@
`default_nettype none

// Incremental PID throttle controller. Each request carries a target and a
// measured speed; the core returns one response with the new servo pulse width
// and the saturated PID increment. The core is a five-register pipeline (input
// register, error/integral, gain products, increment sum, servo position) and
// takes a request every clock cycle unless rsp_ready has held the stages full.
// Each stage holds its item independently, so requests keep flowing while a
// response waits on rsp_ready, until the stages fill up. Registers are to be
// written through the csr port only while the core holds no request in flight;
// the core itself does not enforce this, and csr_ready is always high.

module pid_throttle_slew_limited_core #(
   parameter int FRACTION_BITS = pidts_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire logic signed [pidts_pkg::SPEED_W-1:0]    req_target_speed,
   input  wire logic signed [pidts_pkg::SPEED_W-1:0]    req_measured_speed,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output logic [pidts_pkg::PULSE_W-1:0]                rsp_servo_pulse,
   output logic signed [pidts_pkg::DELTA_W-1:0]         rsp_pid_delta,
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [pidts_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [pidts_pkg::CSR_DATA_W-1:0]        csr_data
);
   import pidts_pkg::*;

   localparam int STAGES = 5;

   cfg_type cfg;

   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES-1:0] ready;
   logic [STAGES-1:0] load;
   logic              drain;

   logic signed [SPEED_W-1:0]  target_ff;
   logic signed [SPEED_W-1:0]  measured_ff;
   logic signed [ERR_W-1:0]    err;
   logic signed [INTEG_W-1:0]  integ;
   logic signed [DERR_W-1:0]   derr;
   logic signed [PROD_P_W-1:0] prod_p;
   logic signed [PROD_I_W-1:0] prod_i;
   logic signed [PROD_D_W-1:0] prod_d;
   logic signed [DELTA_W-1:0]  delta;

   // per-stage handshake: a stage takes new data when empty or moving on
   always_comb begin
      drain    = valid_ff[4] && rsp_ready;
      ready[4] = !valid_ff[4] || rsp_ready;
      ready[3] = !valid_ff[3] || ready[4];
      ready[2] = !valid_ff[2] || ready[3];
      ready[1] = !valid_ff[1] || ready[2];
      ready[0] = !valid_ff[0] || ready[1];
      load[0]  = req_valid && ready[0];
      load[1]  = valid_ff[0] && ready[1];
      load[2]  = valid_ff[1] && ready[2];
      load[3]  = valid_ff[2] && ready[3];
      load[4]  = valid_ff[3] && ready[4];
      valid_in[0] = load[0] || (valid_ff[0] && !load[1]);
      valid_in[1] = load[1] || (valid_ff[1] && !load[2]);
      valid_in[2] = load[2] || (valid_ff[2] && !load[3]);
      valid_in[3] = load[3] || (valid_ff[3] && !load[4]);
      valid_in[4] = load[4] || (valid_ff[4] && !drain);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (load[0]) begin
         target_ff   <= req_target_speed;
         measured_ff <= req_measured_speed;
      end
   end

   assign req_ready = ready[0];
   assign rsp_valid = valid_ff[4];
   assign csr_ready = 1'b1;

   pidts_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   pidts_front u_front (
      .clock       (clock),
      .reset       (reset),
      .load        (load[1]),
      .target      (target_ff),
      .measured    (measured_ff),
      .integ_limit (cfg.integ_limit),
      .err         (err),
      .integ       (integ),
      .derr        (derr)
   );

   pidts_mult u_mult (
      .clock  (clock),
      .load   (load[2]),
      .err    (err),
      .integ  (integ),
      .derr   (derr),
      .cfg    (cfg),
      .prod_p (prod_p),
      .prod_i (prod_i),
      .prod_d (prod_d)
   );

   pidts_sum #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_sum (
      .clock  (clock),
      .load   (load[3]),
      .prod_p (prod_p),
      .prod_i (prod_i),
      .prod_d (prod_d),
      .delta  (delta)
   );

   pidts_servo #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_servo (
      .clock       (clock),
      .reset       (reset),
      .load        (load[4]),
      .delta       (delta),
      .cfg         (cfg),
      .servo_pulse (rsp_servo_pulse),
      .pid_delta   (rsp_pid_delta)
   );

endmodule

`default_nettype wire

@@ src/pidts_csr.sv @@
`default_nettype none

module pidts_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               wr_en,
   input  wire logic [pidts_pkg::CSR_IDX_W-1:0]    wr_index,
   input  wire logic [pidts_pkg::CSR_DATA_W-1:0]   wr_data,
   output pidts_pkg::cfg_type                      cfg
);
   import pidts_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_P_GAIN:    cfg_in.p_gain      = wr_data[GAIN_W-1:0];
            CSR_I_GAIN:    cfg_in.i_gain      = wr_data[GAIN_W-1:0];
            CSR_D_GAIN:    cfg_in.d_gain      = wr_data[GAIN_W-1:0];
            CSR_INTEG_LIM: cfg_in.integ_limit = wr_data[ILIM_W-1:0];
            CSR_SLEW_LIM:  cfg_in.slew_limit  = wr_data[SLEW_W-1:0];
            CSR_PULSE_MAX: cfg_in.pulse_max   = wr_data[PULSE_W-1:0];
            CSR_PULSE_MIN: cfg_in.pulse_min   = wr_data[PULSE_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.p_gain      <= P_GAIN_RESET;
         cfg_ff.i_gain      <= I_GAIN_RESET;
         cfg_ff.d_gain      <= D_GAIN_RESET;
         cfg_ff.integ_limit <= ILIM_RESET;
         cfg_ff.slew_limit  <= SLEW_RESET;
         cfg_ff.pulse_max   <= PMAX_RESET;
         cfg_ff.pulse_min   <= PMIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ src/pidts_front.sv @@
`default_nettype none

module pidts_front (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    load,
   input  wire logic signed [pidts_pkg::SPEED_W-1:0]    target,
   input  wire logic signed [pidts_pkg::SPEED_W-1:0]    measured,
   input  wire logic [pidts_pkg::ILIM_W-1:0]            integ_limit,
   output logic signed [pidts_pkg::ERR_W-1:0]           err,
   output logic signed [pidts_pkg::INTEG_W-1:0]         integ,
   output logic signed [pidts_pkg::DERR_W-1:0]          derr
);
   import pidts_pkg::*;

   localparam int ISUM_W = INTEG_W + 1;

   // integral and previous error double as this stage's output registers
   logic signed [INTEG_W-1:0] integral_sum_ff, integral_sum_in;
   logic signed [ERR_W-1:0]   prev_err_ff, prev_err_in;
   logic signed [DERR_W-1:0]  derr_ff, derr_in;

   logic signed [ERR_W-1:0]   err_now;
   logic signed [ISUM_W-1:0]  isum;
   logic signed [ISUM_W-1:0]  lim_pos;
   logic signed [ISUM_W-1:0]  lim_neg;

   // error, integral with symmetric clamp, error difference
   always_comb begin
      err_now = {target[SPEED_W-1], target} - {measured[SPEED_W-1], measured};
      isum    = {integral_sum_ff[INTEG_W-1], integral_sum_ff}
              + {{(ISUM_W-ERR_W){err_now[ERR_W-1]}}, err_now};
      lim_pos = {{(ISUM_W-ILIM_W){1'b0}}, integ_limit};
      lim_neg = -lim_pos;
      if (isum > lim_pos) begin
         isum = lim_pos;
      end
      if (isum < lim_neg) begin
         isum = lim_neg;
      end
      integral_sum_in = isum[INTEG_W-1:0];
      prev_err_in     = err_now;
      derr_in         = {err_now[ERR_W-1], err_now} - {prev_err_ff[ERR_W-1], prev_err_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_sum_ff <= '0;
         prev_err_ff     <= '0;
      end else if (load) begin
         integral_sum_ff <= integral_sum_in;
         prev_err_ff     <= prev_err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         derr_ff <= derr_in;
      end
   end

   assign err   = prev_err_ff;
   assign integ = integral_sum_ff;
   assign derr  = derr_ff;

endmodule

`default_nettype wire

@@ src/pidts_mult.sv @@
`default_nettype none

module pidts_mult (
   input  wire logic                                    clock,
   input  wire logic                                    load,
   input  wire logic signed [pidts_pkg::ERR_W-1:0]      err,
   input  wire logic signed [pidts_pkg::INTEG_W-1:0]    integ,
   input  wire logic signed [pidts_pkg::DERR_W-1:0]     derr,
   input  pidts_pkg::cfg_type                           cfg,
   output logic signed [pidts_pkg::PROD_P_W-1:0]        prod_p,
   output logic signed [pidts_pkg::PROD_I_W-1:0]        prod_i,
   output logic signed [pidts_pkg::PROD_D_W-1:0]        prod_d
);
   import pidts_pkg::*;

   logic signed [PROD_P_W-1:0] prod_p_ff, prod_p_in;
   logic signed [PROD_I_W-1:0] prod_i_ff, prod_i_in;
   logic signed [PROD_D_W-1:0] prod_d_ff, prod_d_in;

   // three gain products side by side, full precision
   always_comb begin
      prod_p_in = cfg.p_gain * err;
      prod_i_in = cfg.i_gain * integ;
      prod_d_in = cfg.d_gain * derr;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_p_ff <= prod_p_in;
         prod_i_ff <= prod_i_in;
         prod_d_ff <= prod_d_in;
      end
   end

   assign prod_p = prod_p_ff;
   assign prod_i = prod_i_ff;
   assign prod_d = prod_d_ff;

endmodule

`default_nettype wire

@@ src/pidts_sum.sv @@
`default_nettype none

module pidts_sum #(
   parameter int FRACTION_BITS = pidts_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                                    clock,
   input  wire logic                                    load,
   input  wire logic signed [pidts_pkg::PROD_P_W-1:0]   prod_p,
   input  wire logic signed [pidts_pkg::PROD_I_W-1:0]   prod_i,
   input  wire logic signed [pidts_pkg::PROD_D_W-1:0]   prod_d,
   output logic signed [pidts_pkg::DELTA_W-1:0]         delta
);
   import pidts_pkg::*;

   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic signed [SUM_W-1:0]   sum;
   logic signed [SUM_W-1:0]   shifted;
   logic                      over_pos;
   logic                      over_neg;

   // exact sum, floor shift, saturate to the increment width
   always_comb begin
      sum = {{(SUM_W-PROD_P_W){prod_p[PROD_P_W-1]}}, prod_p}
          + {{(SUM_W-PROD_I_W){prod_i[PROD_I_W-1]}}, prod_i}
          + {{(SUM_W-PROD_D_W){prod_d[PROD_D_W-1]}}, prod_d};
      shifted  = sum >>> FRACTION_BITS;
      over_pos = !shifted[SUM_W-1] && (|shifted[SUM_W-2:DELTA_W-1]);
      over_neg = shifted[SUM_W-1] && !(&shifted[SUM_W-2:DELTA_W-1]);
      if (over_pos) begin
         delta_in = {1'b0, {(DELTA_W-1){1'b1}}};
      end else if (over_neg) begin
         delta_in = {1'b1, {(DELTA_W-1){1'b0}}};
      end else begin
         delta_in = shifted[DELTA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         delta_ff <= delta_in;
      end
   end

   assign delta = delta_ff;

endmodule

`default_nettype wire

@@ src/pidts_servo.sv @@
`default_nettype none

module pidts_servo #(
   parameter int FRACTION_BITS = pidts_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    load,
   input  wire logic signed [pidts_pkg::DELTA_W-1:0]    delta,
   input  pidts_pkg::cfg_type                           cfg,
   output logic [pidts_pkg::PULSE_W-1:0]                servo_pulse,
   output logic signed [pidts_pkg::DELTA_W-1:0]         pid_delta
);
   import pidts_pkg::*;

   localparam int POS_W  = PULSE_W + FRACTION_BITS;
   localparam int SPOS_W = POS_W + 2;
   localparam int CMP_W  = DELTA_W + 1;

   logic [POS_W-1:0]          pos_ff, pos_in;
   logic signed [DELTA_W-1:0] delta_ff;

   logic signed [CMP_W-1:0]   d_ext;
   logic signed [CMP_W-1:0]   slew_pos;
   logic signed [CMP_W-1:0]   slew_neg;
   logic signed [CMP_W-1:0]   step_wide;
   logic signed [STEP_W-1:0]  step;
   logic signed [SPOS_W-1:0]  pos;
   logic signed [SPOS_W-1:0]  pmax_s;
   logic signed [SPOS_W-1:0]  pmin_s;

   // slew limit, position update, pulse clamps (min wins over max)
   always_comb begin
      d_ext     = {delta[DELTA_W-1], delta};
      slew_pos  = {{(CMP_W-SLEW_W){1'b0}}, cfg.slew_limit};
      slew_neg  = -slew_pos;
      step_wide = d_ext;
      if (d_ext > slew_pos) begin
         step_wide = slew_pos;
      end
      if (d_ext < slew_neg) begin
         step_wide = slew_neg;
      end
      step   = step_wide[STEP_W-1:0];
      pos    = {2'b00, pos_ff} + {{(SPOS_W-STEP_W){step[STEP_W-1]}}, step};
      pmax_s = {2'b00, cfg.pulse_max, {FRACTION_BITS{1'b0}}};
      pmin_s = {2'b00, cfg.pulse_min, {FRACTION_BITS{1'b0}}};
      if (pos > pmax_s) begin
         pos = pmax_s;
      end
      if (pos < pmin_s) begin
         pos = pmin_s;
      end
      pos_in = pos[POS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= {PULSE_RESET, {FRACTION_BITS{1'b0}}};
      end else if (load) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         delta_ff <= delta;
      end
   end

   assign servo_pulse = pos_ff[POS_W-1:FRACTION_BITS];
   assign pid_delta   = delta_ff;

endmodule

`default_nettype wire
